// ===== src/kmpq_pkg.sv =====
package kmpq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 31;
    localparam int STATUS_W = 3;

    // Stream word widths; the data words are padded to whole bytes.
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 4;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ===== src/keyed_min_priority_queue.sv =====
// Keyed minimum priority queue with update by key.
// Input words arrive on s_tvalid/s_tready: s_tuser is the operation (add or update by
// key, or dequeue the minimum), s_tdata the key and value. Every accepted word gives
// exactly one result word on m_tvalid/m_tready: the dequeued key and value in m_tdata,
// the status and an empty flag in m_tuser.
// Each word is handled by one pass over the entry memory, one entry per cycle through
// its single read port. The read data is registered, and the end of the pass is seen
// once the last read has returned; a write-back state then follows, and then a state
// that loads the output register. The next word is taken in the cycle after the output
// register is loaded. Words are handled one at a time.
// After reset the block sweeps the memory to mark every entry free; s_tready stays low
// during the sweep.
// A result held in the output register does not block the next input word. If the
// receiver stalls, the next result waits inside the block until the output register
// is free, and no further word is taken meanwhile.
module keyed_min_priority_queue #(
    parameter int CAPACITY = kmpq_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kmpq_pkg::S_DATA_W-1:0]  s_tdata,  // key[15:0], value[46:16], zero pad
    input  logic [kmpq_pkg::S_USER_W-1:0]  s_tuser,  // op[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kmpq_pkg::M_DATA_W-1:0]  m_tdata,  // out_key[15:0], out_value[46:16], zero pad
    output logic [kmpq_pkg::M_USER_W-1:0]  m_tuser   // status[2:0], now_empty[3]
);
    import kmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_CNT  = CAPACITY[AW:0];
    localparam logic [CW-1:0] CAP_FULL = CAPACITY[CW-1:0];
    localparam int PAD_W = M_DATA_W - KEY_W - VALUE_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW:0]         issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rd_pend_reg;
    logic [AW-1:0]       rd_idx_reg;

    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic [KEY_W-1:0]    res_key_reg;
    logic [VALUE_W-1:0]  res_value_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_empty_reg;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic                accept;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    entry_t              wr_data;
    entry_t              rd_data;
    logic                out_load;

    logic [KEY_W-1:0]    res_key;
    logic [VALUE_W-1:0]  res_value;
    logic [STATUS_W-1:0] res_status;

    logic                match_found;
    logic [AW-1:0]       match_idx;
    logic                free_found;
    logic [AW-1:0]       free_idx;
    logic                best_found;
    logic [AW-1:0]       best_idx;
    logic [KEY_W-1:0]    best_key;
    logic [VALUE_W-1:0]  best_value;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign rd_en    = (state_reg == S_SCAN) && (issue_cnt_reg != CAP_CNT);
    assign out_load = (state_reg == S_PUSH) && (!m_tvalid_reg || m_tready);

    kmpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    kmpq_scan #(
        .AW (AW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .hit         (rd_pend_reg),
        .hit_idx     (rd_idx_reg),
        .hit_entry   (rd_data),
        .search_key  (key_reg),
        .match_found (match_found),
        .match_idx   (match_idx),
        .free_found  (free_found),
        .free_idx    (free_idx),
        .best_found  (best_found),
        .best_idx    (best_idx),
        .best_key    (best_key),
        .best_value  (best_value)
    );

    // Write-back and result once the pass has seen every entry, and the clearing writes after reset.
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = issue_cnt_reg[AW-1:0];
        wr_data    = '0;
        count_next = count_reg;
        res_key    = '0;
        res_value  = '0;
        res_status = STAT_EMPTY;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_WRITE:
            begin
                if (op_reg == OP_ADD)
                begin
                    priority if (match_found)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = match_idx;
                        wr_data    = '{valid: 1'b1, key: key_reg, value: value_reg};
                        res_status = STAT_UPDATED;
                    end
                    else if (free_found && (count_reg != CAP_FULL))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = free_idx;
                        wr_data    = '{valid: 1'b1, key: key_reg, value: value_reg};
                        count_next = count_reg + 1'b1;
                        res_status = STAT_INSERTED;
                    end
                    else
                    begin
                        res_status = STAT_FULL;
                    end
                end
                else if (best_found)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = best_idx;
                    wr_data    = '{valid: 1'b0, key: best_key, value: best_value};
                    count_next = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                    res_key    = best_key;
                    res_value  = best_value;
                    res_status = STAT_DEQUEUED;
                end
                else
                begin
                    count_next = '0;
                    res_status = STAT_EMPTY;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (issue_cnt_reg == CAP_CNT - 1'b1)
                begin
                    state_next     = S_IDLE;
                    issue_cnt_next = '0;
                end
                else
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next     = S_SCAN;
                    issue_cnt_next = '0;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            issue_cnt_reg <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_en;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_cnt_reg[AW-1:0];
        if (accept)
        begin
            op_reg    <= s_tuser[0];
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
        if (state_reg == S_WRITE)
        begin
            res_key_reg    <= res_key;
            res_value_reg  <= res_value;
            res_status_reg <= res_status;
            res_empty_reg  <= (count_next == '0);
        end
        if (out_load)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_value_reg, res_key_reg};
            m_tuser_reg <= {res_empty_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_FULL)
        else $error("entry count exceeds capacity");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_SCAN))
        else $error("memory read data returned outside a scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !wr_en)
        else $error("memory written while a scan is reading it");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == STAT_EMPTY)) |-> (res_empty_reg && (count_reg == '0)))
        else $error("empty status given while entries remain");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WRITE) && (res_status == STAT_INSERTED)) |=>
            (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance the entry count");

endmodule

// ===== src/kmpq_store.sv =====
module kmpq_store #(
    parameter int DEPTH = kmpq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  kmpq_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output kmpq_pkg::entry_t rd_data
);
    import kmpq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/kmpq_scan.sv =====
module kmpq_scan #(
    parameter int AW = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           hit,
    input  logic [AW-1:0]                  hit_idx,
    input  kmpq_pkg::entry_t               hit_entry,
    input  logic [kmpq_pkg::KEY_W-1:0]     search_key,
    output logic                           match_found,
    output logic [AW-1:0]                  match_idx,
    output logic                           free_found,
    output logic [AW-1:0]                  free_idx,
    output logic                           best_found,
    output logic [AW-1:0]                  best_idx,
    output logic [kmpq_pkg::KEY_W-1:0]     best_key,
    output logic [kmpq_pkg::VALUE_W-1:0]   best_value
);
    import kmpq_pkg::*;

    logic               match_found_reg;
    logic [AW-1:0]      match_idx_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_idx_reg;
    logic               best_found_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [VALUE_W-1:0] best_value_reg;
    logic               better;

    // Smaller value wins; on equal values the larger key wins.
    assign better = !best_found_reg
                    || (hit_entry.value < best_value_reg)
                    || ((hit_entry.value == best_value_reg) && (hit_entry.key > best_key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (start)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (hit)
        begin
            if (hit_entry.valid)
            begin
                if ((hit_entry.key == search_key) && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (better)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && !start)
        begin
            if (hit_entry.valid)
            begin
                if ((hit_entry.key == search_key) && !match_found_reg)
                begin
                    match_idx_reg <= hit_idx;
                end
                if (better)
                begin
                    best_idx_reg   <= hit_idx;
                    best_key_reg   <= hit_entry.key;
                    best_value_reg <= hit_entry.value;
                end
            end
            else if (!free_found_reg)
            begin
                free_idx_reg <= hit_idx;
            end
        end
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign free_found  = free_found_reg;
    assign free_idx    = free_idx_reg;
    assign best_found  = best_found_reg;
    assign best_idx    = best_idx_reg;
    assign best_key    = best_key_reg;
    assign best_value  = best_value_reg;

endmodule

// ===== verif/kmpq_checker.sv =====
module kmpq_checker #(
    parameter int CAPACITY = kmpq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kmpq_pkg::S_DATA_W-1:0] s_tdata,  // key[15:0], value[46:16], zero pad
    input  logic [kmpq_pkg::S_USER_W-1:0] s_tuser,  // op[0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kmpq_pkg::M_DATA_W-1:0] m_tdata,  // out_key[15:0], out_value[46:16], zero pad
    input  logic [kmpq_pkg::M_USER_W-1:0] m_tuser,  // status[2:0], now_empty[3]
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import kmpq_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                now_empty;
    } outcome_t;

    logic [KEY_W-1:0]   slot_key   [CAPACITY];
    logic [VALUE_W-1:0] slot_value [CAPACITY];
    bit                 slot_used  [CAPACITY];
    int                 used_count;
    outcome_t           awaited[$];
    int                 result_index;

    // Works out the result of one input word and updates the local copy of the table.
    function automatic outcome_t serve_word(logic op, logic [KEY_W-1:0] k,
                                            logic [VALUE_W-1:0] v);
        outcome_t res;
        int       free_idx;
        int       best;
        res = '0;
        if (op == OP_ADD) begin
            free_idx = -1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i]) begin
                    if (slot_key[i] == k) begin
                        slot_value[i] = v;
                        res.status    = STAT_UPDATED;
                        res.now_empty = (used_count == 0);
                        return res;
                    end
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (free_idx < 0 || used_count >= CAPACITY) begin
                res.status = STAT_FULL;
            end else begin
                slot_key[free_idx]   = k;
                slot_value[free_idx] = v;
                slot_used[free_idx]  = 1'b1;
                used_count++;
                res.status = STAT_INSERTED;
            end
        end else begin
            best = -1;
            // Smallest value wins; on equal values the larger key is served first.
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i] && (best < 0 || slot_value[i] < slot_value[best] ||
                    (slot_value[i] == slot_value[best] && slot_key[i] > slot_key[best])))
                    best = i;
            end
            if (best < 0) begin
                used_count = 0;
                res.status = STAT_EMPTY;
            end else begin
                slot_used[best] = 1'b0;
                if (used_count > 0)
                    used_count--;
                res.key    = slot_key[best];
                res.value  = slot_value[best];
                res.status = STAT_DEQUEUED;
            end
        end
        res.now_empty = (used_count == 0);
        return res;
    endfunction

    task automatic log_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_result(logic [M_DATA_W-1:0] d, logic [M_USER_W-1:0] u);
        outcome_t want;
        outcome_t got;
        got.key       = d[KEY_W-1:0];
        got.value     = d[KEY_W +: VALUE_W];
        got.status    = u[STATUS_W-1:0];
        got.now_empty = u[STATUS_W];
        if (awaited.size() == 0) begin
            log_failure($sformatf(
                "result word %0d with nothing awaited: key %h value %h status %0d empty %b",
                result_index, got.key, got.value, got.status, got.now_empty));
        end else begin
            want = awaited.pop_front();
            if (got.key !== want.key || got.value !== want.value ||
                got.status !== want.status || got.now_empty !== want.now_empty)
                log_failure($sformatf({"result word %0d: expected key %h value %h",
                            " status %0d empty %b, got key %h value %h",
                            " status %0d empty %b"},
                            result_index, want.key, want.value, want.status, want.now_empty,
                            got.key, got.value, got.status, got.now_empty));
        end
        result_index++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            used_count   = 0;
            result_index = 0;
            fail_count   = 0;
            awaited.delete();
            pending <= 0;
        end else begin
            // The result is taken before the new word so an early result is never
            // matched against the word accepted on the same edge.
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                awaited.push_back(serve_word(s_tuser[0], s_tdata[KEY_W-1:0],
                                             s_tdata[KEY_W +: VALUE_W]));
            pending <= awaited.size();
        end
    end

endmodule

// ===== verif/keyed_min_priority_queue_test.sv =====
module keyed_min_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kmpq_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int WORD_COUNT  = 1650;
    localparam int KEY_POOL_N  = 24;
    localparam int HOLD_CYCLES = 20 * CAPACITY;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } burst_e;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [S_USER_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    int                  fail_count;
    int                  pending;
    int                  cycles = 0;
    bit                  calm;
    bit                  hold_req;
    logic [KEY_W-1:0]    key_pool [KEY_POOL_N];

    keyed_min_priority_queue #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    kmpq_checker #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Small values are favoured so that equal priorities occur often.
    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return VALUE_W'($urandom_range(0, 15));
        if (roll < 9)
            return VALUE_W'($urandom());
        return ($urandom_range(0, 1) == 1) ? '1 : '0;
    endfunction

    task automatic send_word(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - KEY_W - VALUE_W){1'b0}}, v, k};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stops offering words until every awaited result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: a random stall before each word, and one long hold-off on request
    // so that the block backs up and stalls its input.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        int     sent;
        int     burst;
        int     n;
        burst_e kind;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ADD;
        calm     = 1'b0;
        hold_req = 1'b0;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = KEY_W'($urandom());
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, extremes, a tie on value, updates and draining.
        send_word(OP_DEQ, 16'h0000, 31'h0000_0000);
        send_word(OP_DEQ, 16'hFFFF, 31'h7FFF_FFFF);
        send_word(OP_ADD, 16'hFFFF, 31'h7FFF_FFFF);
        send_word(OP_ADD, 16'h0000, 31'h0000_0000);
        send_word(OP_ADD, 16'h5A5A, 31'h0000_0000);
        send_word(OP_ADD, 16'h0000, 31'h7FFF_FFFF);
        send_word(OP_ADD, 16'hA5A5, 31'h2AAA_AAAA);
        send_word(OP_ADD, 16'h5A5A, 31'h5555_5555);
        send_word(OP_DEQ, 16'h1234, 31'h0000_0001);
        send_word(OP_DEQ, 16'h0000, 31'h0000_0000);
        send_word(OP_DEQ, 16'h0000, 31'h0000_0000);
        send_word(OP_DEQ, 16'h0000, 31'h0000_0000);
        send_word(OP_DEQ, 16'h0000, 31'h0000_0000);
        wait_for_results();

        sent  = 0;
        burst = 0;
        while (sent < WORD_COUNT)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if (burst == 0)
                kind = BURST_FILL;
            else if (burst == 1)
            begin
                kind     = BURST_MIXED;
                hold_req = 1'b1;
            end
            else
                kind = burst_e'($urandom_range(0, 3));
            // A fill burst offers CAPACITY to CAPACITY + 12 adds, enough to fill an empty table when the keys differ.
            n = (kind == BURST_FILL) ? $urandom_range(CAPACITY, CAPACITY + 12)
                                     : $urandom_range(20, 70);
            repeat (n)
            begin
                case (kind)
                    BURST_FILL:
                        send_word(OP_ADD, KEY_W'($urandom()), pick_value());
                    BURST_DRAIN:
                        send_word(OP_DEQ, KEY_W'($urandom()), VALUE_W'($urandom()));
                    BURST_MIXED:
                        if ($urandom_range(0, 1) == 0)
                            send_word(OP_ADD, key_pool[$urandom_range(0, KEY_POOL_N - 1)],
                                      pick_value());
                        else
                            send_word(OP_DEQ, KEY_W'($urandom()), VALUE_W'($urandom()));
                    default:
                        send_word(($urandom_range(0, 1) == 0) ? OP_ADD : OP_DEQ,
                                  KEY_W'($urandom()), VALUE_W'($urandom()));
                endcase
                sent++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_for_results();
            burst++;
        end

        wait_for_results();
        repeat (CAPACITY + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
